// ===== hdl/dsf_pkg.sv =====
// Shared types, widths and constants for the damped spring force block.
package dsf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned IN_W      = 32;
  localparam int unsigned N_IN      = 12;
  localparam int unsigned IN_DATA_W = IN_W * N_IN;
  localparam int unsigned OUT_DATA_W = 48 + 3 * 32;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned DW   = 33;   // endpoint difference, signed
  localparam int unsigned SQ_W = 66;   // sum of squared differences
  localparam int unsigned LW   = 33;   // spring length
  localparam int unsigned EMW  = 33;   // |l - l0|

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 2'd2;

  localparam logic [CFG_W-1:0] STIFFNESS_RST   = 32'd65536;
  localparam logic [CFG_W-1:0] REST_LENGTH_RST = 32'd65536;
  localparam logic [CFG_W-1:0] DAMPING_RST     = 32'd0;

  typedef struct packed {
    logic [CFG_W-1:0] stiffness;
    logic [CFG_W-1:0] rest_length;
    logic [CFG_W-1:0] damping;
  } cfg_t;

  // Position and velocity differences, second endpoint minus first.
  typedef struct packed {
    logic [2:0][DW-1:0] d;
    logic [2:0][DW-1:0] dv;
  } diff_t;

endpackage

// ===== hdl/dsf_front.sv =====
// Input stage: accept endpoint requests and form position and velocity differences.
module dsf_front import dsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic [IN_DATA_W-1:0] s_data_i,
  output logic                 s_ready_o,
  output logic                 diff_valid_o,
  output diff_t                diff_o,
  input  logic                 diff_ready_i
);

  logic  v_q;
  diff_t df_q, df_d;

  always_comb begin
    logic [IN_W-1:0] pa, pb, va, vb;
    for (int i = 0; i < 3; i++) begin
      pa = s_data_i[IN_W*i +: IN_W];
      pb = s_data_i[IN_W*(3+i) +: IN_W];
      va = s_data_i[IN_W*(6+i) +: IN_W];
      vb = s_data_i[IN_W*(9+i) +: IN_W];
      df_d.d[i]  = {pb[IN_W-1], pb} - {pa[IN_W-1], pa};
      df_d.dv[i] = {vb[IN_W-1], vb} - {va[IN_W-1], va};
    end
  end

  assign s_ready_o    = !v_q || diff_ready_i;
  assign diff_valid_o = v_q;
  assign diff_o       = df_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (s_ready_o) begin
      v_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      df_q <= df_d;
    end
  end

endmodule

// ===== hdl/dsf_fifo.sv =====
// Short queue between the input stage and the arithmetic pipeline.
module dsf_fifo import dsf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  input  diff_t wr_data_i,
  output logic  wr_ready_o,
  output logic  rd_valid_o,
  output diff_t rd_data_o,
  input  logic  rd_ready_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  diff_t         mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != (AW+1)'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/dsf_back.sv =====
// Arithmetic pipeline: length, normal, damping projection, energy and gradient.
module dsf_back import dsf_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  input  diff_t              in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [47:0]        energy_o,
  output logic signed [31:0] grad_x_o,
  output logic signed [31:0] grad_y_o,
  output logic signed [31:0] grad_z_o,
  output logic               zero_length_o,
  output logic               saturated_o
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NW  = F + 1;          // |n| bits
  localparam int unsigned NSW = F + 2;          // signed n
  localparam int unsigned PRW = NSW + DW;       // n * dv
  localparam int unsigned PJW = PRW + 2;        // projection
  localparam int unsigned PH  = (PJW + 1) / 2;  // projection chunk
  localparam int unsigned T2W = CFG_W + 2 * PH;
  localparam int unsigned KEW = CFG_W + EMW;
  localparam int unsigned SSW = F + 72;
  localparam int unsigned SC  = (SSW + 2) / 3;  // |s| chunk
  localparam int unsigned PPW = SC + NW;
  localparam int unsigned GW  = 3 * SC + NW;
  localparam int unsigned RW  = LW + 3;         // root remainder
  localparam int unsigned RMW = DW + 1;         // divider remainder
  localparam int unsigned ENW = 98;

  typedef struct packed {
    diff_t           df;
    logic [LW-1:0]   l;
    logic [EMW-1:0]  emag;
    logic            eneg;
    logic            lz;
    logic [2:0]      dneg;
    logic [2:0]      dbit;
  } mid_t;

  typedef struct packed {
    logic [2:0][NW-1:0] nmag;
    logic [2:0]         nneg;
    logic               lz;
    logic [47:0]        energy;
    logic               esat;
  } tail_t;

  logic adv;
  logic out_v_q;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- squares and sum
  logic              p0_v_q;
  diff_t             p0_df_q;
  logic [SQ_W-2:0]   p0_sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (adv) begin
      p0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DW-1:0] ad;
    if (adv) begin
      p0_df_q <= in_data_i;
      for (int i = 0; i < 3; i++) begin
        ad = in_data_i.d[i][DW-1] ? -in_data_i.d[i] : in_data_i.d[i];
        p0_sq_q[i] <= (SQ_W-1)'(ad) * (SQ_W-1)'(ad);
      end
    end
  end

  // ---------------- square root, one result bit per stage
  logic            sq_v_q    [LW+1];
  diff_t           sq_df_q   [LW+1];
  logic [SQ_W-1:0] sq_rad_q  [LW+1];
  logic [RW-1:0]   sq_rem_q  [LW+1];
  logic [LW-1:0]   sq_root_q [LW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_df_q[0]   <= p0_df_q;
      sq_rad_q[0]  <= SQ_W'(p0_sq_q[0]) + SQ_W'(p0_sq_q[1]) + SQ_W'(p0_sq_q[2]);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    logic [RW-1:0] remx, trial;
    assign remx  = {sq_rem_q[j][RW-3:0], sq_rad_q[j][SQ_W-1 -: 2]};
    assign trial = {1'b0, sq_root_q[j], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_df_q[j+1]  <= sq_df_q[j];
        sq_rad_q[j+1] <= {sq_rad_q[j][SQ_W-3:0], 2'b00};
        if (remx >= trial) begin
          sq_rem_q[j+1]  <= remx - trial;
          sq_root_q[j+1] <= {sq_root_q[j][LW-2:0], 1'b1};
        end else begin
          sq_rem_q[j+1]  <= remx;
          sq_root_q[j+1] <= {sq_root_q[j][LW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- length error and divider set-up
  logic              dv_v_q   [NW+1];
  mid_t              dv_mid_q [NW+1];
  logic [2:0][RMW-1:0] dv_rem_q [NW+1];
  logic [2:0][NW-1:0]  dv_q_q   [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= sq_v_q[LW];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [LW:0] e;
    logic [DW-1:0]      ad;
    if (adv) begin
      e = $signed({1'b0, sq_root_q[LW]}) - $signed({2'b00, cfg_i.rest_length});
      dv_mid_q[0].df   <= sq_df_q[LW];
      dv_mid_q[0].l    <= sq_root_q[LW];
      dv_mid_q[0].eneg <= e[LW];
      dv_mid_q[0].emag <= e[LW] ? EMW'(-e) : EMW'(e);
      dv_mid_q[0].lz   <= (sq_root_q[LW] == '0);
      for (int i = 0; i < 3; i++) begin
        ad = sq_df_q[LW].d[i][DW-1] ? -sq_df_q[LW].d[i] : sq_df_q[LW].d[i];
        dv_mid_q[0].dneg[i] <= sq_df_q[LW].d[i][DW-1];
        dv_mid_q[0].dbit[i] <= ad[0];
        dv_rem_q[0][i]      <= RMW'(ad >> 1);
      end
      dv_q_q[0] <= '0;
    end
  end

  // ---------------- normal vector, one quotient bit per stage and lane
  for (genvar k = 0; k < NW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [RMW-1:0] remx;
      logic           nb;
      if (adv) begin
        dv_mid_q[k+1] <= dv_mid_q[k];
        for (int i = 0; i < 3; i++) begin
          nb   = (k == 0) ? dv_mid_q[k].dbit[i] : 1'b0;
          remx = {dv_rem_q[k][i][RMW-2:0], nb};
          if (remx >= RMW'(dv_mid_q[k].l)) begin
            dv_rem_q[k+1][i] <= remx - RMW'(dv_mid_q[k].l);
            dv_q_q[k+1][i]   <= {dv_q_q[k][i][NW-2:0], 1'b1};
          end else begin
            dv_rem_q[k+1][i] <= remx;
            dv_q_q[k+1][i]   <= {dv_q_q[k][i][NW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- tail: projection, energy, gradient
  logic [8:0]              tv_q;      // valid bits of stages after the divider
  tail_t                   tl_q [9];
  tail_t                   tl_d0;
  logic signed [NSW-1:0]   nsig_q [3];
  diff_t                   p3_df_q;
  logic [2*EMW-1:0]        ee_q;
  logic [KEW-1:0]          kem_q;
  logic                    p3_eneg_q;
  logic signed [PRW-1:0]   pr_q [3];
  logic [KEW-1:0]          en_a_q, en_b_q;
  logic signed [SSW-1:0]   t1s_q [5];
  logic signed [PJW-1:0]   proj_q;
  logic [2*PH-1:0]         pabs_q;
  logic                    pneg_q [3];
  logic [CFG_W+PH-1:0]     t2a_q, t2b_q;
  logic [T2W-1:0]          t2_q;
  logic signed [SSW-1:0]   s_q;
  logic [3*SC-1:0]         smag_q;
  logic                    sneg_q [2];
  logic [PPW-1:0]          pp_q [3][3];
  logic [47:0]             energy_q;
  logic [2:0][31:0]        grad_q;
  logic                    lz_q, sat_q;

  always_comb begin
    tl_d0 = '0;
    tl_d0.lz = dv_mid_q[NW].lz;
    for (int i = 0; i < 3; i++) begin
      tl_d0.nmag[i] = dv_q_q[NW][i];
      tl_d0.nneg[i] = dv_mid_q[NW].dneg[i] && (dv_q_q[NW][i] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      tv_q    <= {tv_q[7:0], dv_v_q[NW]};
      out_v_q <= tv_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SSW-1:0]      t1m;
    logic [ENW-1:0]      enf, ensh;
    logic signed [PJW-1:0] pj;
    logic [GW-1:0]       g, gsh, lim;
    logic                neg;
    tail_t               tl2;
    logic                sat_v;
    if (adv) begin
      // carry the tail fields along; stage two also picks up the energy
      tl_q[0] <= tl_d0;
      tl_q[1] <= tl_q[0];
      for (int k = 3; k < 9; k++) begin
        tl_q[k] <= tl_q[k-1];
      end

      // signed normal, squared error and stiffness term
      for (int i = 0; i < 3; i++) begin
        nsig_q[i] <= dv_mid_q[NW].dneg[i] ? -$signed({1'b0, dv_q_q[NW][i]})
                                          :  $signed({1'b0, dv_q_q[NW][i]});
      end
      p3_df_q   <= dv_mid_q[NW].df;
      p3_eneg_q <= dv_mid_q[NW].eneg;
      ee_q      <= (2*EMW)'(dv_mid_q[NW].emag) * (2*EMW)'(dv_mid_q[NW].emag);
      kem_q     <= KEW'(cfg_i.stiffness) * KEW'(dv_mid_q[NW].emag);

      // projection terms, energy partial products, signed stiffness term
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= PRW'(nsig_q[i]) * PRW'($signed(p3_df_q.dv[i]));
      end
      en_a_q <= KEW'(ee_q[EMW-1:0]) * KEW'(cfg_i.stiffness);
      en_b_q <= KEW'(ee_q[2*EMW-1:EMW]) * KEW'(cfg_i.stiffness);
      t1m = SSW'(kem_q) << F;
      t1s_q[0] <= p3_eneg_q ? -$signed(t1m) : $signed(t1m);
      for (int k = 1; k < 5; k++) begin
        t1s_q[k] <= t1s_q[k-1];
      end

      // projection sum, energy with saturation
      proj_q <= PJW'(pr_q[0]) + PJW'(pr_q[1]) + PJW'(pr_q[2]);
      enf  = ENW'(en_a_q) + (ENW'(en_b_q) << EMW);
      ensh = enf >> (2*F + 1);
      tl2  = tl_q[1];
      if (ensh[ENW-1:48] != '0) begin
        tl2.energy = '1;
        tl2.esat   = 1'b1;
      end else begin
        tl2.energy = ensh[47:0];
        tl2.esat   = 1'b0;
      end
      tl_q[2] <= tl2;

      // magnitude of the projection
      pj = proj_q;
      pabs_q    <= pj[PJW-1] ? (2*PH)'(-pj) : (2*PH)'(pj);
      pneg_q[0] <= pj[PJW-1];
      pneg_q[1] <= pneg_q[0];
      pneg_q[2] <= pneg_q[1];

      // damping term in two halves
      t2a_q <= (CFG_W+PH)'(cfg_i.damping) * (CFG_W+PH)'(pabs_q[PH-1:0]);
      t2b_q <= (CFG_W+PH)'(cfg_i.damping) * (CFG_W+PH)'(pabs_q[2*PH-1:PH]);
      t2_q  <= T2W'(t2a_q) + (T2W'(t2b_q) << PH);

      // scalar force
      s_q <= pneg_q[2] ? t1s_q[4] - $signed(SSW'(t2_q))
                       : t1s_q[4] + $signed(SSW'(t2_q));
      smag_q    <= s_q[SSW-1] ? (3*SC)'(-s_q) : (3*SC)'(s_q);
      sneg_q[0] <= s_q[SSW-1];
      sneg_q[1] <= sneg_q[0];

      // scalar times normal, three chunks per lane
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          pp_q[i][c] <= PPW'(smag_q[SC*c +: SC]) * PPW'(tl_q[7].nmag[i]);
        end
      end

      // reassemble, scale, saturate
      sat_v    = tl_q[8].esat;
      energy_q <= tl_q[8].energy;
      lz_q     <= tl_q[8].lz;
      for (int i = 0; i < 3; i++) begin
        g   = GW'(pp_q[i][0]) + (GW'(pp_q[i][1]) << SC) + (GW'(pp_q[i][2]) << (2*SC));
        gsh = g >> (4*F);
        neg = sneg_q[1] ^ tl_q[8].nneg[i];
        lim = neg ? GW'(33'h1_0000_0000 >> 1) : GW'(32'h7fff_ffff);
        if (tl_q[8].lz) begin
          grad_q[i] <= '0;
        end else if (gsh > lim) begin
          grad_q[i] <= neg ? 32'h8000_0000 : 32'h7fff_ffff;
          sat_v      = 1'b1;
        end else begin
          grad_q[i] <= neg ? -gsh[31:0] : gsh[31:0];
        end
      end
      sat_q <= sat_v;
    end
  end

  assign out_valid_o   = out_v_q;
  assign energy_o      = energy_q;
  assign grad_x_o      = $signed(grad_q[0]);
  assign grad_y_o      = $signed(grad_q[1]);
  assign grad_z_o      = $signed(grad_q[2]);
  assign zero_length_o = lz_q;
  assign saturated_o   = sat_q;

  a_root_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[LW] |-> (sq_rem_q[LW] <= RW'({sq_root_q[LW], 1'b0})))
    else $error("square root remainder above twice the root");

  a_quot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[NW] && !dv_mid_q[NW].lz) |->
      (dv_q_q[NW][0] <= (NW'(1) << F)) && (dv_q_q[NW][1] <= (NW'(1) << F)) &&
      (dv_q_q[NW][2] <= (NW'(1) << F)))
    else $error("normal component above one");

  a_zero_grad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && lz_q) |-> (grad_q == '0))
    else $error("nonzero gradient for coinciding endpoints");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(grad_q) && $stable(energy_q)))
    else $error("result changed while stalled");

endmodule

// ===== hdl/damped_spring_force.sv =====
// Path from an input request to its result runs through the 33-stage square root and the
// FRAC_BITS + 1 stage divider.
// Throughput: one spring per cycle while the result side takes requests; a four-entry
// queue lets the input side keep accepting during short output stalls.
// Reset (rst_ni, async, active low) empties all stages and the queue and loads
// stiffness = 1.0, rest_length = 1.0, damping = 0; no clearing pass is needed.
module damped_spring_force import dsf_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // request side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
  // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z (32 bit each)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // result side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // energy[47:0], grad_x[79:48], grad_y[111:80], grad_z[143:112]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // zero_length[0], saturated[1]
  output logic [OUT_USER_W-1:0] m_tuser
);

  cfg_t  cfg_q;
  diff_t fr_data, q_data;
  logic  fr_valid, fr_ready, q_valid, q_ready;
  logic [47:0]        energy;
  logic signed [31:0] grad_x, grad_y, grad_z;
  logic               zero_length, saturated;

  // Config registers: write when enabled, drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiffness   <= STIFFNESS_RST;
      cfg_q.rest_length <= REST_LENGTH_RST;
      cfg_q.damping     <= DAMPING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STIFFNESS:   cfg_q.stiffness   <= cfg_wdata_i;
        REG_REST_LENGTH: cfg_q.rest_length <= cfg_wdata_i;
        REG_DAMPING:     cfg_q.damping     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: accept a request and form the endpoint differences.
  dsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_tvalid),
    .s_data_i     (s_tdata),
    .s_ready_o    (s_tready),
    .diff_valid_o (fr_valid),
    .diff_o       (fr_data),
    .diff_ready_i (fr_ready)
  );

  // Queue: decouple the front from pipeline stalls.
  dsf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_data_i  (fr_data),
    .wr_ready_o (fr_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data),
    .rd_ready_i (q_ready)
  );

  // Back: length, normal, projection, energy and gradient; the last stage
  // is the result register and the whole pipeline advances when it frees up.
  dsf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (q_valid),
    .in_data_i     (q_data),
    .in_ready_o    (q_ready),
    .out_valid_o   (m_tvalid),
    .out_ready_i   (m_tready),
    .energy_o      (energy),
    .grad_x_o      (grad_x),
    .grad_y_o      (grad_y),
    .grad_z_o      (grad_z),
    .zero_length_o (zero_length),
    .saturated_o   (saturated)
  );

  assign m_tdata = {grad_z, grad_y, grad_x, energy};
  assign m_tuser = {saturated, zero_length};

endmodule

// ===== dv/dsf_checker.sv =====
// Scoreboard for the damped spring force block: predicts each result and compares it.
`timescale 1ns / 100ps
module dsf_checker import dsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [OUT_USER_W-1:0] m_tuser,
  output int unsigned           mismatches_o,
  output int                    pending_o
);

  typedef struct {
    logic [47:0] energy;
    logic [31:0] grad [3];
    logic        zero_len;
    logic        sat;
  } spring_res_t;

  localparam logic [127:0] ENERGY_MAX = 128'hFFFF_FFFF_FFFF;

  logic [CFG_W-1:0] k_q, l0_q, b_q;
  spring_res_t      expected_q [$];

  function automatic logic [127:0] mag(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  // Exact integer math at full width; only the outputs clip.
  function automatic spring_res_t predict_force(logic [IN_DATA_W-1:0] req);
    longint       d [3];
    longint       dv [3];
    longint       n [3];
    longint       e;
    longint       proj;
    logic [127:0] sum, c, l, emag, en, t1, t2, s, g, lim;
    logic         sneg, neg;
    spring_res_t  r;
    sum  = '0;
    proj = 0;
    l    = '0;
    sneg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = longint'($signed(req[32*(3+i) +: 32])) - longint'($signed(req[32*i +: 32]));
      dv[i] = longint'($signed(req[32*(9+i) +: 32])) - longint'($signed(req[32*(6+i) +: 32]));
      sum   = sum + mag(d[i]) * mag(d[i]);
    end
    // Bitwise floor square root.
    for (int bt = 35; bt >= 0; bt--) begin
      c = l | (128'd1 << bt);
      if (c * c <= sum) l = c;
    end
    e    = longint'(l) - longint'(l0_q);
    emag = mag(e);
    en   = (emag * emag * 128'(k_q)) >> 33;
    r.sat      = en > ENERGY_MAX;
    r.energy   = r.sat ? ENERGY_MAX[47:0] : en[47:0];
    r.zero_len = (l == 0);
    for (int i = 0; i < 3; i++) r.grad[i] = '0;
    if (l != 0) begin
      for (int i = 0; i < 3; i++) begin
        n[i] = (d[i] * 65536) / longint'(l);
        proj = proj + n[i] * dv[i];
      end
      t1 = (128'(k_q) * emag) << 16;
      t2 = 128'(b_q) * mag(proj);
      // Combine the elastic and damping terms as sign and magnitude.
      if ((e < 0) == (proj < 0)) begin
        s    = t1 + t2;
        sneg = e < 0;
      end else if (t2 <= t1) begin
        s    = t1 - t2;
        sneg = e < 0;
      end else begin
        s    = t2 - t1;
        sneg = proj < 0;
      end
      for (int i = 0; i < 3; i++) begin
        g   = (s * mag(n[i])) >> 64;
        neg = (sneg != (n[i] < 0)) && (g != 0);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (g > lim) begin
          g     = lim;
          r.sat = 1'b1;
        end
        r.grad[i] = neg ? 32'(-g) : g[31:0];
      end
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= STIFFNESS_RST;
      l0_q <= REST_LENGTH_RST;
      b_q  <= DAMPING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STIFFNESS:   k_q  <= cfg_wdata_i;
        REG_REST_LENGTH: l0_q <= cfg_wdata_i;
        REG_DAMPING:     b_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    spring_res_t x;
    logic        bad;
    if (rst_ni && s_tvalid && s_tready) expected_q = {expected_q, predict_force(s_tdata)};
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatches_o++;
        if (mismatches_o <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        x   = expected_q.pop_front();
        bad = (m_tdata[47:0] !== x.energy) || (m_tdata[79:48] !== x.grad[0])
           || (m_tdata[111:80] !== x.grad[1]) || (m_tdata[143:112] !== x.grad[2])
           || (m_tuser[0] !== x.zero_len) || (m_tuser[1] !== x.sat);
        if (bad) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("mismatch: exp e=%h g=%h %h %h zl=%b sat=%b, got e=%h g=%h %h %h zl=%b sat=%b",
                     x.energy, x.grad[0], x.grad[1], x.grad[2], x.zero_len, x.sat,
                     m_tdata[47:0], m_tdata[79:48], m_tdata[111:80], m_tdata[143:112],
                     m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: clock, reset, spring requests, config phases and the verdict.
`timescale 1ns / 100ps
module tb_top;
  import dsf_pkg::*;

  localparam int LATENCY   = FRAC_BITS_DEF + 48;
  localparam int STALL_MAX = 5000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  int unsigned           mismatches;
  int                    pending;

  // Sender pacing and receiver hold-off controls.
  int burst_left = 0;
  bit no_gaps    = 1'b0;
  bit hold_req   = 1'b0;

  damped_spring_force dut (.*);

  dsf_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: switch among four stall patterns; a hold request first blocks with ready low.
  initial begin
    int mode;
    int cnt;
    mode = 0;
    cnt  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (cnt % 64 == 0) mode = $urandom_range(0, 3);
      cnt++;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((cnt / 5) % 2 == 0);
      endcase
    end
  end

  // Watchdog: give up after too many cycles without progress.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (!s_tvalid && pending == 0))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and wait until every expected result is back, then let the pipe flush.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 16) @(negedge clk_i);
  endtask

  task automatic set_springs(logic [CFG_W-1:0] k, logic [CFG_W-1:0] l0, logic [CFG_W-1:0] b);
    drain();
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_REST_LENGTH, l0);
    write_reg(REG_DAMPING, b);
  endtask

  // Offer one spring; valid stays high within a burst, gaps fall between bursts.
  task automatic send_spring(logic [IN_DATA_W-1:0] req);
    if (burst_left == 0 && !no_gaps) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack(logic [31:0] f [12]);
    logic [IN_DATA_W-1:0] v;
    for (int i = 0; i < 12; i++) v[32*i +: 32] = f[i];
    return v;
  endfunction

  function automatic logic [31:0] wide_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Mostly physical springs: nearby endpoints with moderate velocities, plus wide noise.
  function automatic logic [IN_DATA_W-1:0] random_spring();
    logic [31:0] f [12];
    int          kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 6) begin
        f[i]     = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        f[3 + i] = f[i] + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        f[6 + i] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        f[9 + i] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      end else if (kind == 6) begin
        // coinciding endpoints
        f[i]     = $urandom();
        f[3 + i] = f[i];
        f[6 + i] = $urandom();
        f[9 + i] = $urandom();
      end else begin
        f[i]     = wide_field();
        f[3 + i] = wide_field();
        f[6 + i] = wide_field();
        f[9 + i] = wide_field();
      end
    end
    return pack(f);
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_spring(random_spring());
  endtask

  task automatic directed_springs();
    logic [31:0] f [12];
    // all zero: coinciding endpoints at rest
    for (int i = 0; i < 12; i++) f[i] = '0;
    send_spring(pack(f));
    // unit spring along each axis, and a diagonal
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 0; i < 12; i++) f[i] = '0;
      f[3 + ax] = 32'h0001_0000;
      f[9 + ax] = 32'hFFFF_0000;
      send_spring(pack(f));
    end
    for (int i = 0; i < 12; i++) f[i] = '0;
    f[3] = 32'd1;
    f[4] = 32'd1;
    send_spring(pack(f));
    // widest separations in both directions, extreme velocities
    for (int i = 0; i < 3; i++) begin
      f[i] = 32'h8000_0000; f[3 + i] = 32'h7FFF_FFFF;
      f[6 + i] = 32'h7FFF_FFFF; f[9 + i] = 32'h8000_0000;
    end
    send_spring(pack(f));
    for (int i = 0; i < 3; i++) begin
      f[i] = 32'h7FFF_FFFF; f[3 + i] = 32'h8000_0000;
      f[6 + i] = 32'h8000_0000; f[9 + i] = 32'h7FFF_FFFF;
    end
    send_spring(pack(f));
    // coinciding endpoints with motion
    for (int i = 0; i < 12; i++) f[i] = $urandom();
    for (int i = 0; i < 3; i++) f[3 + i] = f[i];
    send_spring(pack(f));
    // compressed and stretched springs with closing and opening velocities
    for (int j = 0; j < 6; j++) begin
      for (int i = 0; i < 12; i++) f[i] = '0;
      f[3] = (j < 3) ? 32'h0000_8000 : 32'h0003_0000;
      f[4] = 32'h0000_4000 * j;
      f[9] = (j % 2) ? 32'h0002_0000 : 32'hFFFE_0000;
      send_spring(pack(f));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values first
    directed_springs();
    run_random(60);

    // extremes: saturate everything
    set_springs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    write_reg(2'd3, $urandom());
    directed_springs();
    run_random(150);

    set_springs(32'h0, 32'hFFFF_FFFF, 32'h0);
    directed_springs();
    run_random(100);

    // moderate settings; one phase fills the block, one runs without gaps
    for (int ph = 0; ph < 4; ph++) begin
      set_springs($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0008_0000),
                  $urandom_range(0, 32'h0004_0000));
      no_gaps = (ph == 1);
      if (ph == 2) hold_req = 1'b1;
      run_random(250);
      no_gaps = 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dsf_pkg.sv
hdl/dsf_front.sv
hdl/dsf_fifo.sv
hdl/dsf_back.sv
hdl/damped_spring_force.sv
dv/dsf_checker.sv
dv/tb_top.sv
